FILE: hw/rtl/sphere_frustum_cull_defines.svh
// assertion macros for the sphere frustum cull block
`ifndef SPHERE_FRUSTUM_CULL_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SFC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked at the next clock edge
`define SFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/sfc_pkg.sv
`default_nettype none
package sfc_pkg;

   localparam int PlaneCount   = 6;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 64;
   localparam int SqrtSteps    = 16;
   localparam int PipeStages   = 24;

   // signed 16 bit field at position pos of a packed word
   function automatic logic signed [15:0] fld16(input logic [47:0] w, input int pos);
      fld16 = w[pos +: 16];
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sphere_frustum_cull.sv
`default_nettype none
// channel | ports                          | dir
// req     | req_valid req_stall req_*      | in, one object word
// rsp     | rsp_valid rsp_stall rsp_visible| out, one visibility word
// csr     | csr_write csr_index csr_data   | in, plane registers
//
// one word in per cycle unless the output stalls; 24 register stages, made of
// the column squares, the square root pipeline (17 stages), length max, radius
// multiply and round, two plane stages and the visibility register
// the whole pipeline advances only when the output register is free or taken,
// so a stall freezes every stage and nothing is lost or repeated
// reset clears the valid bits and the plane registers
`include "sphere_frustum_cull_defines.svh"
module sphere_frustum_cull import sfc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [47:0]             req_basis_x,
   input  wire logic [47:0]             req_basis_y,
   input  wire logic [47:0]             req_basis_z,
   input  wire logic [47:0]             req_translation,
   input  wire logic [47:0]             req_local_center,
   input  wire logic [15:0]             req_local_radius,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_visible,
   input  wire logic                    csr_write,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_data
);
   // stage map: sqrt out at 17, len max 18, radius mult 19, round 20,
   // plane tests 21 to 22, visibility 23; center ready at 1 and delayed along
   localparam int Lat = PipeStages;

   logic [63:0] plane_ff [PlaneCount];
   logic        vld_ff [Lat];
   logic        en;

   // whole pipe stalls only when the last stage holds a word that is refused
   assign en        = !(vld_ff[Lat-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PlaneCount; i++) plane_ff[i] <= '0;
      end else if (csr_write && (32'(csr_index) < PlaneCount)) begin
         plane_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lat; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < Lat; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // world center, ready after 2 register stages
   logic [47:0] row_x, row_y, row_z;
   assign row_x = {req_basis_z[15:0],  req_basis_y[15:0],  req_basis_x[15:0]};
   assign row_y = {req_basis_z[31:16], req_basis_y[31:16], req_basis_x[31:16]};
   assign row_z = {req_basis_z[47:32], req_basis_y[47:32], req_basis_x[47:32]};
   logic signed [15:0] wc [3];
   sfc_center u_cx (.clock, .en, .basis_row(row_x), .center(req_local_center),
                    .trans(fld16(req_translation, 0)),  .world(wc[0]));
   sfc_center u_cy (.clock, .en, .basis_row(row_y), .center(req_local_center),
                    .trans(fld16(req_translation, 16)), .world(wc[1]));
   sfc_center u_cz (.clock, .en, .basis_row(row_z), .center(req_local_center),
                    .trans(fld16(req_translation, 32)), .world(wc[2]));

   // carry the center from stage 2 to stage 20
   localparam int CDly = 18;
   logic [47:0] cd_ff [CDly];
   always_ff @(posedge clock) begin
      if (en) begin
         cd_ff[0] <= {wc[2], wc[1], wc[0]};
         for (int i = 1; i < CDly; i++) cd_ff[i] <= cd_ff[i-1];
      end
   end

   // column squared lengths, one register stage
   logic [32:0] sq_ff [3];
   logic [15:0] lr_ff [19];
   logic [47:0] cols [3];
   assign cols[0] = req_basis_x;
   assign cols[1] = req_basis_y;
   assign cols[2] = req_basis_z;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= 33'($unsigned(32'(fld16(cols[k], 0)  * fld16(cols[k], 0))))
                      + 33'($unsigned(32'(fld16(cols[k], 16) * fld16(cols[k], 16))))
                      + 33'($unsigned(32'(fld16(cols[k], 32) * fld16(cols[k], 32))));
         end
         lr_ff[0] <= req_local_radius;
         for (int i = 1; i < 19; i++) lr_ff[i] <= lr_ff[i-1];
      end
   end

   logic [16:0] len [3];
   for (genvar k = 0; k < 3; k++) begin : g_len
      sfc_sqrt u_sqrt (.clock, .en, .radicand(sq_ff[k]), .root(len[k]));
   end

   // max length, radius product, rounding
   logic [16:0] max_ff;
   logic [32:0] prod_ff;
   logic [15:0] rad_ff;
   logic [47:0] wcr_ff;
   logic [19:0] rsh;
   always_comb rsh = 20'((prod_ff + 33'd4096) >> 13);
   always_ff @(posedge clock) begin
      if (en) begin
         max_ff  <= (len[0] > len[1]) ? ((len[0] > len[2]) ? len[0] : len[2])
                                      : ((len[1] > len[2]) ? len[1] : len[2]);
         prod_ff <= lr_ff[18] * max_ff;
         rad_ff  <= (rsh > 20'd65535) ? 16'hffff : rsh[15:0];
         wcr_ff  <= cd_ff[CDly-1];
      end
   end

   logic [PlaneCount-1:0] pass;
   for (genvar p = 0; p < PlaneCount; p++) begin : g_plane
      sfc_plane u_plane (.clock, .en, .plane(plane_ff[p]),
                         .wx(wcr_ff[15:0]), .wy(wcr_ff[31:16]), .wz(wcr_ff[47:32]),
                         .rad(rad_ff), .pass(pass[p]));
   end

   logic vis_ff;
   always_ff @(posedge clock) begin
      if (en) vis_ff <= &pass;
   end
   assign rsp_visible = vis_ff;

   // a refused word holds the whole pipe
   `SFC_ASSERT_IMPL(a_stall_holds, clock, reset, rsp_valid && rsp_stall, req_stall)
   // with no word on the output the pipe keeps moving
   `SFC_ASSERT_IMPL(a_flow, clock, reset, !rsp_valid, !req_stall)
   // a refused word stays on the output
   `SFC_ASSERT_NEXT(a_keep, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // the end of the pipe follows the stage before it
   `SFC_ASSERT_NEXT(a_shift, clock, reset, !req_stall && vld_ff[Lat-2], rsp_valid)
endmodule
`default_nettype wire

FILE: hw/rtl/sfc_center.sv
`default_nettype none
// world center: two stage multiply accumulate, one component per instance
module sfc_center import sfc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [47:0]        basis_row,   // bx, by, bz for this component
   input  wire logic [47:0]        center,
   input  wire logic signed [15:0] trans,
   output logic signed [15:0]      world
);
   logic signed [31:0] p0_ff, p1_ff, p2_ff;
   logic signed [31:0] t_ff;
   logic signed [35:0] acc_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff  <= fld16(basis_row, 0)  * fld16(center, 0);
         p1_ff  <= fld16(basis_row, 16) * fld16(center, 16);
         p2_ff  <= fld16(basis_row, 32) * fld16(center, 32);
         t_ff   <= 32'(trans) <<< 12;
         acc_ff <= 36'(p0_ff) + 36'(p1_ff) + 36'(p2_ff) + 36'(t_ff) + 36'sd2048;
      end
   end

   // half-up rounding shift and saturate to q12.4
   logic signed [23:0] sh;
   always_comb begin
      sh = acc_ff[35:12];
      if (sh > 24'sd32767)       world = 16'sh7fff;
      else if (sh < -24'sd32768) world = 16'sh8000;
      else                       world = sh[15:0];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/sfc_sqrt.sv
`default_nettype none
// pipelined bit pair square root of a 33 bit value, one result bit per stage
module sfc_sqrt import sfc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [32:0] radicand,
   output logic [16:0]      root
);
   logic [33:0] val_ff [SqrtSteps+1];
   logic [33:0] rem_ff [SqrtSteps+1];
   logic [16:0] res_ff [SqrtSteps+1];

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff[0] <= {1'b0, radicand};
         rem_ff[0] <= '0;
         res_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < SqrtSteps + 1; s++) begin : g_step
      if (s < SqrtSteps) begin : g_mid
         logic [33:0] r_in;
         logic [33:0] trial;
         always_comb begin
            r_in  = {rem_ff[s][31:0], val_ff[s][33:32]};
            trial = {15'd0, res_ff[s], 2'b01};
         end
         always_ff @(posedge clock) begin
            if (en) begin
               val_ff[s+1] <= {val_ff[s][31:0], 2'b00};
               if (r_in >= trial) begin
                  rem_ff[s+1] <= r_in - trial;
                  res_ff[s+1] <= {res_ff[s][15:0], 1'b1};
               end else begin
                  rem_ff[s+1] <= r_in;
                  res_ff[s+1] <= {res_ff[s][15:0], 1'b0};
               end
            end
         end
      end
   end

   // the last step folds in the lowest pair of the 34 bit radicand
   logic [33:0] r_last, t_last;
   always_comb begin
      r_last = {rem_ff[SqrtSteps][31:0], val_ff[SqrtSteps][33:32]};
      t_last = {15'd0, res_ff[SqrtSteps], 2'b01};
      root   = (r_last >= t_last) ? {res_ff[SqrtSteps][15:0], 1'b1}
                                  : {res_ff[SqrtSteps][15:0], 1'b0};
   end
endmodule
`default_nettype wire

FILE: hw/rtl/sfc_plane.sv
`default_nettype none
// one plane test, two stages
module sfc_plane import sfc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [63:0]        plane,
   input  wire logic signed [15:0] wx,
   input  wire logic signed [15:0] wy,
   input  wire logic signed [15:0] wz,
   input  wire logic [15:0]        rad,
   output logic                    pass
);
   logic signed [31:0] px_ff, py_ff, pz_ff, po_ff;
   logic signed [31:0] r_ff;
   logic signed [35:0] d_ff;
   logic signed [35:0] nr_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= fld16(plane[47:0], 0)  * wx;
         py_ff <= fld16(plane[47:0], 16) * wy;
         pz_ff <= fld16(plane[47:0], 32) * wz;
         po_ff <= 32'($signed(plane[63:48])) <<< 14;
         r_ff  <= $signed({2'b00, rad, 14'd0});
         d_ff  <= 36'(px_ff) + 36'(py_ff) + 36'(pz_ff) - 36'(po_ff);
         nr_ff <= -36'(r_ff);
      end
   end

   assign pass = d_ff > nr_ff;
endmodule
`default_nettype wire

FILE: test/tb_sphere_frustum_cull.sv
`timescale 1ns / 1ps
module tb_sphere_frustum_cull;
   import sfc_pkg::*;

   // plane register indexes, in register order
   localparam logic [CsrIdxWidth-1:0] LEFT_PLANE   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] RIGHT_PLANE  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] FAR_PLANE    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] NEAR_PLANE   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] TOP_PLANE    = 3'd4;
   localparam logic [CsrIdxWidth-1:0] BOTTOM_PLANE = 3'd5;
   // indexes past the last plane, writes there must be dropped
   localparam logic [CsrIdxWidth-1:0] SPARE_IDX_A  = 3'd6;
   localparam logic [CsrIdxWidth-1:0] SPARE_IDX_B  = 3'd7;

   localparam int USE_PREDICTOR = -1;
   localparam int DRAIN_CYCLES  = 40; // pipeline depth is 24
   localparam int ITEMS_PER_SET = 100;

   typedef struct {
      logic [47:0] bx, by, bz, tr, ctr;
      logic [15:0] rad;
      int          want; // typed-in visibility, or USE_PREDICTOR
   } object_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [47:0]             req_basis_x, req_basis_y, req_basis_z;
   logic [47:0]             req_translation, req_local_center;
   logic [15:0]             req_local_radius;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_visible;
   logic                    csr_write;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_data;

   logic [63:0] plane_regs [PlaneCount]; // testbench copy of the plane registers
   logic        visible_q [$];            // expected visibility, oldest first
   int          error_count;
   bit          no_idle;

   sphere_frustum_cull uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_basis_x(req_basis_x), .req_basis_y(req_basis_y), .req_basis_z(req_basis_z),
      .req_translation(req_translation), .req_local_center(req_local_center),
      .req_local_radius(req_local_radius),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_visible(rsp_visible),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous cap on the whole run
   initial begin
      #3ms;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      error_count++;
   endtask

   // signed 16 bit lane of a packed word
   function automatic longint lane(input logic [63:0] w, input int k);
      logic [15:0] v;
      v = w[16*k +: 16];
      return longint'($signed(v));
   endfunction

   function automatic logic [47:0] pack3(input int x, input int y, input int z);
      logic [15:0] a, b, c;
      a = x[15:0];
      b = y[15:0];
      c = z[15:0];
      return {c, b, a};
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // bounding sphere against the six planes, all in exact integer arithmetic
   function automatic logic predict_visible(input object_type o);
      logic [47:0]     cols [3];
      longint          world [3];
      longint          acc, plane_dist, rad18;
      longint unsigned len, maxlen, prod, wrad;
      logic            vis;
      cols[0] = o.bx;
      cols[1] = o.by;
      cols[2] = o.bz;
      for (int i = 0; i < 3; i++) begin
         acc = lane(o.tr, i) * 4096;
         for (int k = 0; k < 3; k++) acc += lane(cols[k], i) * lane(o.ctr, k);
         // half-up rounding from 16 to 4 fraction bits, then clamp
         acc = (acc + 2048) >>> 12;
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         world[i] = acc;
      end
      maxlen = 0;
      for (int k = 0; k < 3; k++) begin
         len = int_sqrt(longint'(lane(cols[k], 0) * lane(cols[k], 0)
                      + lane(cols[k], 1) * lane(cols[k], 1)
                      + lane(cols[k], 2) * lane(cols[k], 2)));
         if (len > maxlen) maxlen = len;
      end
      prod = longint'(o.rad) * maxlen;
      wrad = (prod + 4096) >> 13;
      if (wrad > 65535) wrad = 65535;
      rad18 = longint'(wrad) * 16384;
      vis = 1'b1;
      for (int p = 0; p < PlaneCount; p++) begin
         plane_dist = lane(plane_regs[p], 0) * world[0] + lane(plane_regs[p], 1) * world[1]
                    + lane(plane_regs[p], 2) * world[2] - lane(plane_regs[p], 3) * 16384;
         if (!(plane_dist > -rad18)) vis = 1'b0;
      end
      return vis;
   endfunction

   task automatic write_plane(input logic [CsrIdxWidth-1:0] idx, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx < PlaneCount) plane_regs[idx] = value;
   endtask

   // block idle: no word in flight, then the pipeline tail empties too
   task automatic drain;
      while (visible_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_object(input object_type o);
      int gap;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_basis_x      <= o.bx;
      req_basis_y      <= o.by;
      req_basis_z      <= o.bz;
      req_translation  <= o.tr;
      req_local_center <= o.ctr;
      req_local_radius <= o.rad;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (o.want == USE_PREDICTOR) visible_q.push_back(predict_visible(o));
      else visible_q.push_back(o.want[0]);
   endtask

   function automatic logic [15:0] pick_extreme;
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h7FFF;
         3: return 16'h8000;
         default: return 16'h0001;
      endcase
   endfunction

   function automatic logic [47:0] rand48;
      return 48'({$urandom, $urandom});
   endfunction

   function automatic int srand(input int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic object_type random_object;
      object_type o;
      int      mode;
      int      s;
      mode = $urandom_range(0, 9);
      o.want = USE_PREDICTOR;
      if (mode < 6) begin
         // plausible rigid transform: scaled axes, small shear, scene-sized offsets
         s = $urandom_range(1024, 12000);
         o.bx  = pack3(s + srand(300), srand(300), srand(300));
         o.by  = pack3(srand(300), s + srand(300), srand(300));
         o.bz  = pack3(srand(300), srand(300), s + srand(300));
         o.tr  = pack3(srand(4000), srand(4000), srand(4000));
         o.ctr = pack3(srand(800), srand(800), srand(800));
         o.rad = 16'($urandom_range(0, 1200));
      end else if (mode < 9) begin
         o.bx  = rand48();
         o.by  = rand48();
         o.bz  = rand48();
         o.tr  = rand48();
         o.ctr = rand48();
         o.rad = 16'($urandom);
      end else begin
         o.bx  = {pick_extreme(), pick_extreme(), pick_extreme()};
         o.by  = {pick_extreme(), pick_extreme(), pick_extreme()};
         o.bz  = {pick_extreme(), pick_extreme(), pick_extreme()};
         o.tr  = {pick_extreme(), pick_extreme(), pick_extreme()};
         o.ctr = {pick_extreme(), pick_extreme(), pick_extreme()};
         o.rad = pick_extreme();
      end
      return o;
   endfunction

   // axis-aligned box-like frustum with offsets around the scene
   function automatic logic [63:0] axis_plane(input int axis, input bit neg);
      int n [3];
      int off;
      n = '{0, 0, 0};
      n[axis] = neg ? -16384 : 16384;
      off = srand(3000);
      return {off[15:0], pack3(n[0], n[1], n[2])};
   endfunction

   // directed words; planes are still at reset, so visible iff world radius nonzero
   object_type directed [] = '{
      '{48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 16'h0000, 0},
      // identity, radius 1.0 -> world radius 0.5
      '{48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000,
        48'h0, 48'h0, 16'h0010, 1},
      '{48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000,
        48'h0, 48'h0, 16'h0000, 0},
      // zero basis kills any radius
      '{48'h0, 48'h0, 48'h0, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 16'hFFFF, 0},
      // tiny radius rounds away to zero
      '{48'h0000_0000_0001, 48'h0, 48'h0, 48'h0, 48'h0, 16'h0001, 0},
      '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
        48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, USE_PREDICTOR},
      '{48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
        48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 16'hFFFF, 1},
      '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
        48'h8000_8000_8000, 48'h8000_8000_8000, 16'hFFFF, 1},
      '{48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h0, 48'h8000_7FFF_8000,
        48'h7FFF_8000_7FFF, 16'h8000, USE_PREDICTOR},
      '{48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA, 48'h5555_5555_AAAA,
        48'hAAAA_AAAA_5555, 48'h5555_AAAA_AAAA, 16'h5555, USE_PREDICTOR}
   };

   // response side: random stall bursts, one assignment per edge
   int stall_left;
   always @(posedge clock) begin
      logic next_stall;
      next_stall = 1'b0;
      if (reset || no_idle) begin
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         next_stall = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         next_stall = 1'b1;
      end
      rsp_stall <= next_stall;
   end

   // check every accepted result word against the oldest expectation
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (visible_q.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = visible_q.pop_front();
            if (rsp_visible !== want)
               report_mismatch($sformatf("visible %b, expected %b", rsp_visible, want));
         end
      end
   end

   initial begin
      object_type o;
      error_count = 0;
      no_idle     = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      rsp_stall   = 1'b0;
      csr_write   = 1'b0;
      csr_index   = LEFT_PLANE;
      csr_data    = '0;
      req_basis_x = '0;
      req_basis_y = '0;
      req_basis_z = '0;
      req_translation  = '0;
      req_local_center = '0;
      req_local_radius = '0;
      for (int p = 0; p < PlaneCount; p++) plane_regs[p] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_object(directed[i]);

      // each set of planes gets its own batch of random words
      for (int set = 0; set < 6; set++) begin
         req_valid <= 1'b0;
         drain();
         case (set)
            0: begin
               // every normal and offset at -1 lsb
               write_plane(LEFT_PLANE,   '1);
               write_plane(RIGHT_PLANE,  '1);
               write_plane(FAR_PLANE,    '1);
               write_plane(NEAR_PLANE,   '1);
               write_plane(TOP_PLANE,    '1);
               write_plane(BOTTOM_PLANE, '1);
            end
            1: begin
               write_plane(LEFT_PLANE,   64'h7FFF_7FFF_7FFF_7FFF);
               write_plane(RIGHT_PLANE,  64'h8000_8000_8000_8000);
               write_plane(FAR_PLANE,    64'h8000_7FFF_8000_7FFF);
               write_plane(NEAR_PLANE,   64'h7FFF_8000_7FFF_8000);
               write_plane(TOP_PLANE,    64'h0000_0000_0000_0000);
               write_plane(BOTTOM_PLANE, 64'h0000_7FFF_0000_0000);
            end
            2, 3: begin
               write_plane(LEFT_PLANE,   axis_plane(0, 1'b0));
               write_plane(RIGHT_PLANE,  axis_plane(0, 1'b1));
               write_plane(FAR_PLANE,    axis_plane(2, 1'b1));
               write_plane(NEAR_PLANE,   axis_plane(2, 1'b0));
               write_plane(TOP_PLANE,    axis_plane(1, 1'b1));
               write_plane(BOTTOM_PLANE, axis_plane(1, 1'b0));
               // out of range indexes must leave the planes alone
               write_plane(SPARE_IDX_A, 64'(rand48()));
               write_plane(SPARE_IDX_B, '1);
            end
            default: begin
               write_plane(LEFT_PLANE,   {$urandom, $urandom});
               write_plane(RIGHT_PLANE,  {$urandom, $urandom});
               write_plane(FAR_PLANE,    {$urandom, $urandom});
               write_plane(NEAR_PLANE,   {$urandom, $urandom});
               write_plane(TOP_PLANE,    {$urandom, $urandom});
               write_plane(BOTTOM_PLANE, {$urandom, $urandom});
            end
         endcase
         // final batch runs back to back with no stalls
         if (set == 5) no_idle = 1'b1;
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            o = random_object();
            send_object(o);
         end
      end
      req_valid <= 1'b0;

      while (visible_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_center.sv
hw/rtl/sfc_sqrt.sv
hw/rtl/sfc_plane.sv
hw/rtl/sphere_frustum_cull.sv
test/tb_sphere_frustum_cull.sv
